[sv/tspc_pkg.sv]
// types, codes and update functions shared by the servo position controller
package tspc_pkg;

	// reset values of the configuration registers and of the state, the homing back-off step and the saturation value
	localparam logic [7:0] MIN_FLOOR_RST  = 8'd85;
	localparam logic [7:0] MAX_ANGLE_RST  = 8'd180;
	localparam logic [7:0] MARGIN_RST     = 8'd35;
	localparam logic [7:0] HOME_START_RST = 8'd110;
	localparam logic [7:0] ANGLE_RST      = 8'd170;
	localparam logic [7:0] HOME_RISE      = 8'd55;
	localparam logic [7:0] ANGLE_SAT      = 8'd255;

	// request codes
	typedef logic [2:0] req_t;
	localparam req_t REQ_JOG  = 3'd0;
	localparam req_t REQ_SET  = 3'd1;
	localparam req_t REQ_BULK = 3'd2;
	localparam req_t REQ_HOME = 3'd3;
	localparam req_t REQ_TICK = 3'd4;

	// jog directions
	localparam logic [7:0] DIR_DOWN = 8'd0;
	localparam logic [7:0] DIR_UP   = 8'd1;

	// servo numbers as they arrive on the command
	localparam logic [7:0] SERVO_ONE   = 8'd1;
	localparam logic [7:0] SERVO_TWO   = 8'd2;
	localparam logic [7:0] SERVO_THREE = 8'd3;

	// status codes
	typedef logic [1:0] status_t;
	localparam status_t STS_OK        = 2'd0;
	localparam status_t STS_BAD_SERVO = 2'd1;
	localparam status_t STS_BAD_DIR   = 2'd2;
	localparam status_t STS_BUSY      = 2'd3;

	// register indexes
	typedef logic [7:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MIN_FLOOR  = 8'd0;
	localparam cfg_idx_t CFG_MAX_ANGLE  = 8'd1;
	localparam cfg_idx_t CFG_MARGIN     = 8'd2;
	localparam cfg_idx_t CFG_HOME_START = 8'd3;

	typedef struct packed {
		req_t       req_type;
		logic [7:0] servo_number;
		logic [7:0] direction;
		logic [7:0] step_size;
		logic [7:0] angle_one;
		logic [7:0] angle_two;
		logic [7:0] angle_three;
		logic [2:0] switch_open;
	} cmd_t;

	typedef struct packed {
		logic [7:0] pos_one;
		logic [7:0] pos_two;
		logic [7:0] pos_three;
		logic [7:0] limit_one;
		logic [7:0] limit_two;
		logic [7:0] limit_three;
		status_t    status;
		logic       homing_busy;
	} res_t;

	typedef struct packed {
		cfg_idx_t   index;
		logic [7:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0] min_floor;
		logic [7:0] max_angle;
		logic [7:0] safety_margin;
		logic [7:0] home_start_angle;
	} cfg_regs_t;

	typedef struct packed {
		logic [2:0][7:0] angle;
		logic [2:0][7:0] limit;
		logic [2:0]      reached;
		logic            homing;
	} state_t;

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? ANGLE_SAT : s[7:0];
	endfunction

	function automatic logic [7:0] move_up(input logic [7:0] pos, input logic [7:0] step,
			input logic [7:0] max_a);
		logic [7:0] p;
		p = sat_add(pos, step);
		return (p > max_a) ? max_a : p;
	endfunction

	// never below the limit, also when the step passes zero
	function automatic logic [7:0] move_down(input logic [7:0] pos, input logic [7:0] step,
			input logic [7:0] lim);
		logic [7:0] d;
		d = pos - step;
		return ((step > pos) || (d < lim)) ? lim : d;
	endfunction

	// inverted window: angles below the lower bound get it, all others the upper bound
	function automatic logic [7:0] set_clamped(input logic [7:0] ang, input logic [7:0] lim,
			input logic [7:0] margin, input logic [7:0] max_a);
		logic [7:0] lo;
		lo = sat_add(lim, margin);
		if (ang < lo)
			return lo;
		else if (ang > max_a)
			return max_a;
		else
			return ang;
	endfunction

endpackage

[sv/tspc_stream_if.sv]
// valid/ready channel carrying one payload struct per beat
interface tspc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/tspc_step.sv]
// next-state and result logic for one command
module tspc_step (
	input  tspc_pkg::cmd_t      cmd,
	input  tspc_pkg::state_t    st,
	input  tspc_pkg::cfg_regs_t regs,
	output tspc_pkg::state_t    st_nxt,
	output tspc_pkg::res_t      res
);

	logic [2:0]      hit;
	logic            servo_ok;
	logic [2:0][7:0] bulk;
	tspc_pkg::status_t status;

	assign hit = {cmd.servo_number == tspc_pkg::SERVO_THREE,
		cmd.servo_number == tspc_pkg::SERVO_TWO,
		cmd.servo_number == tspc_pkg::SERVO_ONE};
	assign servo_ok = |hit;
	assign bulk = {cmd.angle_three, cmd.angle_two, cmd.angle_one};

	always_comb begin
		st_nxt = st;
		status = tspc_pkg::STS_OK;
		if ((cmd.req_type <= tspc_pkg::REQ_HOME) && st.homing) begin
			status = tspc_pkg::STS_BUSY;
		end else begin
			case (cmd.req_type)
				tspc_pkg::REQ_JOG: begin
					if (!servo_ok) begin
						status = tspc_pkg::STS_BAD_SERVO;
					end else if (cmd.direction == tspc_pkg::DIR_UP) begin
						for (int i = 0; i < 3; i++)
							if (hit[i])
								st_nxt.angle[i] = tspc_pkg::move_up(st.angle[i],
									cmd.step_size, regs.max_angle);
					end else if (cmd.direction == tspc_pkg::DIR_DOWN) begin
						for (int i = 0; i < 3; i++)
							if (hit[i])
								st_nxt.angle[i] = tspc_pkg::move_down(st.angle[i],
									cmd.step_size, st.limit[i]);
					end else begin
						status = tspc_pkg::STS_BAD_DIR;
					end
				end
				tspc_pkg::REQ_SET: begin
					if (!servo_ok) begin
						status = tspc_pkg::STS_BAD_SERVO;
					end else begin
						for (int i = 0; i < 3; i++)
							if (hit[i])
								st_nxt.angle[i] = tspc_pkg::set_clamped(cmd.angle_one,
									st.limit[i], regs.safety_margin, regs.max_angle);
					end
				end
				tspc_pkg::REQ_BULK: begin
					for (int i = 0; i < 3; i++)
						st_nxt.angle[i] = tspc_pkg::set_clamped(bulk[i], st.limit[i],
							regs.safety_margin, regs.max_angle);
				end
				tspc_pkg::REQ_HOME: begin
					for (int i = 0; i < 3; i++)
						st_nxt.angle[i] = regs.home_start_angle;
					st_nxt.reached = '0;
					st_nxt.homing = 1'b1;
				end
				tspc_pkg::REQ_TICK: begin
					if (st.homing) begin
						for (int i = 0; i < 3; i++) begin
							if (!st.reached[i]) begin
								if (cmd.switch_open[i]) begin
									st_nxt.angle[i] = tspc_pkg::move_down(st.angle[i],
										8'd1, st.limit[i]);
								end else begin
									st_nxt.reached[i] = 1'b1;
									st_nxt.limit[i] = st.angle[i];
								end
							end
						end
						// all switches closed: back off and finish
						if (&st_nxt.reached) begin
							for (int i = 0; i < 3; i++)
								st_nxt.angle[i] = tspc_pkg::move_up(st_nxt.angle[i],
									tspc_pkg::HOME_RISE, regs.max_angle);
							st_nxt.homing = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.pos_one     = st_nxt.angle[0];
		res.pos_two     = st_nxt.angle[1];
		res.pos_three   = st_nxt.angle[2];
		res.limit_one   = st_nxt.limit[0];
		res.limit_two   = st_nxt.limit[1];
		res.limit_three = st_nxt.limit[2];
		res.status      = status;
		res.homing_busy = st_nxt.homing;
	end

endmodule

[sv/three_servo_position_controller_top.sv]
// top level of the three-servo position controller
// Keeps a commanded angle and a learned lower limit for each of three servos
// and updates them from one command beat at a time: jog, set one servo, bulk
// set, start homing and homing tick. Every accepted command gives exactly one
// result beat holding all angles and limits after the command, a status code
// and the homing flag. Throughput is one command per clock cycle while the
// result side takes beats; a command passes the input register, the single
// combinational update and the result register. The input register takes a
// new command while the previous result still waits on the output side.
// Configuration registers (min floor, max angle, safety margin, home start
// angle) are written through the cfg channel, which is always ready; a min
// floor write also reloads all three limits unless a command commits in the
// same cycle. Register writes are meant for when no command is in flight.
module three_servo_position_controller_top (
	input  logic                clk,
	input  logic                arst_n,
	tspc_stream_if.sink         cmd,
	tspc_stream_if.source       res,
	tspc_stream_if.sink         cfg
);

	// input stage
	tspc_pkg::cmd_t cmd_s1;
	logic           vld_s1;

	// result stage
	tspc_pkg::res_t res_s2;
	logic           vld_s2;

	// architectural state and configuration
	tspc_pkg::state_t    st_q;
	tspc_pkg::state_t    st_nxt;
	tspc_pkg::cfg_regs_t regs_q;
	tspc_pkg::res_t      res_nxt;

	logic adv;
	logic cfg_wr;

	// the input stage moves on when the result stage is empty or being drained
	assign adv       = vld_s1 && (!vld_s2 || res.ready);
	assign cmd.ready = !vld_s1 || adv;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign res.valid = vld_s2;
	assign res.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready)
			cmd_s1 <= cmd.data;
	end

	tspc_step u_step (
		.cmd    (cmd_s1),
		.st     (st_q),
		.regs   (regs_q),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (res.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	// state commits with the command; otherwise a min floor write reloads the limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				st_q.angle[i] <= tspc_pkg::ANGLE_RST;
				st_q.limit[i] <= tspc_pkg::MIN_FLOOR_RST;
			end
			st_q.reached <= '0;
			st_q.homing  <= 1'b0;
		end else if (adv) begin
			st_q <= st_nxt;
		end else if (cfg_wr && (cfg.data.index == tspc_pkg::CFG_MIN_FLOOR)) begin
			for (int i = 0; i < 3; i++)
				st_q.limit[i] <= cfg.data.wdata;
		end
	end

	// configuration registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_floor        <= tspc_pkg::MIN_FLOOR_RST;
			regs_q.max_angle        <= tspc_pkg::MAX_ANGLE_RST;
			regs_q.safety_margin    <= tspc_pkg::MARGIN_RST;
			regs_q.home_start_angle <= tspc_pkg::HOME_START_RST;
		end else if (cfg_wr) begin
			case (cfg.data.index)
				tspc_pkg::CFG_MIN_FLOOR:  regs_q.min_floor        <= cfg.data.wdata;
				tspc_pkg::CFG_MAX_ANGLE:  regs_q.max_angle        <= cfg.data.wdata;
				tspc_pkg::CFG_MARGIN:     regs_q.safety_margin    <= cfg.data.wdata;
				tspc_pkg::CFG_HOME_START: regs_q.home_start_angle <= cfg.data.wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

[sv/tspc_checker.sv]
// port-level checks for the servo position controller, bound to the top level
module tspc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input tspc_pkg::res_t out_data
);

	logic [1:0] occ_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// commands taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else if (in_beat && !out_beat) begin
			occ_q <= occ_q + 2'd1;
		end else if (!in_beat && out_beat) begin
			occ_q <= occ_q - 2'd1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occ_q != 2'd0) && (occ_q != 2'd3))
		else $error("result without a pending command");

	a_busy_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == tspc_pkg::STS_BUSY) |-> out_data.homing_busy)
		else $error("busy status while homing is idle");

	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_data.status == tspc_pkg::STS_BAD_SERVO) ||
		(out_data.status == tspc_pkg::STS_BAD_DIR)) |-> !out_data.homing_busy)
		else $error("servo or direction error reported during homing");

endmodule

bind three_servo_position_controller_top tspc_checker u_tspc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_data  (res.data)
);
